### hw/rtl/fgr_pkg.sv
// Shared constants, action codes and the root table for the gain ramp fader.
`default_nettype none

package fgr_pkg;

    // Action codes carried in the kind field
    localparam logic [2:0] KIND_FRAME = 3'd0;
    localparam logic [2:0] KIND_RAMP  = 3'd1;
    localparam logic [2:0] KIND_MUTE  = 3'd2;
    localparam logic [2:0] KIND_LIMIT = 3'd3;
    localparam logic [2:0] KIND_CLIP  = 3'd4;
    localparam logic [2:0] KIND_UNDER = 3'd5;
    localparam logic [2:0] KIND_OVER  = 3'd6;
    localparam logic [2:0] KIND_READ  = 3'd7;

    // Gain formats and limits
    localparam logic signed [23:0] GAIN_MAX24 = 24'sh7FFFFF;
    localparam logic signed [23:0] GAIN_MIN24 = 24'sh800000;
    localparam logic signed [23:0] MUTE_Q16   = -24'sd5242880;
    localparam logic signed [15:0] APPL_MIN   = 16'sh8000;
    localparam logic [19:0]        LIN_MAX    = 20'hFFFFF;

    // log2(10)/5120 in Q32: turns Q7.8 dB into a base-2 exponent
    localparam logic signed [22:0] LOG_K      = 23'sd2786635;

    // One factor 2^(2^-k) per fraction bit
    localparam int ROOT_STEPS = 24;

    typedef logic [30:0] root_tbl_t [ROOT_STEPS];

    // Floor square root, one result bit per pass
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_v;
        v     = v_in;
        res   = 64'd0;
        bit_v = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (v >= res + bit_v)
            begin
                v   = v - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else
            begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // Repeated square roots of 2.0 in Q30, evaluated at elaboration
    function automatic root_tbl_t build_roots();
        root_tbl_t   tbl;
        logic [63:0] root;
        root = 64'd2 << 30;
        for (int k = 0; k < ROOT_STEPS; k++)
        begin
            root   = isqrt64(root << 30);
            tbl[k] = root[30:0];
        end
        return tbl;
    endfunction

    localparam root_tbl_t ROOT_TBL = build_roots();

endpackage

`default_nettype wire

### hw/rtl/frame_gain_ramp_with_counters.sv
// Per-frame dB gain fader with ramp divider, exponent unit and event counters.
//
//  channel | direction | beat carries
//  --------+-----------+-------------------------------------------------------
//  cfg     | in        | headroom (Q7.8 dB)
//  in      | in        | kind, target_gain, ramp_frames, clipped_count
//  out     | out       | linear_gain, applied_gain, five counters, frames_left
//
// Event kinds (mute, counters, ramp jump) complete in the idle state. A ramp with a
// frame count runs 25 passes of the restoring divider plus a fixup. Frame and read
// beats form the exponent product, then the shared Q30 multiplier walks the 24
// fraction bits, then the result is rounded; above the linear range the multiplier
// is skipped. The output register holds
// a finished beat while the next beat is taken; a result waits in place until
// the output register is free. Reset clears all gain state and counters.
`default_nettype none

module frame_gain_ramp_with_counters
    import fgr_pkg::*;
(
    input  wire                clk,
    input  wire                rst_n,
    // configuration
    input  wire                cfg_valid,
    output logic               cfg_ready,
    input  wire  [14:0]        headroom,
    // input beats
    input  wire                in_valid,
    output logic               in_ready,
    input  wire  [2:0]         kind,
    input  wire  signed [15:0] target_gain,
    input  wire  [15:0]        ramp_frames,
    input  wire  [15:0]        clipped_count,
    // result beats
    output logic               out_valid,
    input  wire                out_ready,
    output logic [19:0]        linear_gain,
    output logic signed [15:0] applied_gain,
    output logic [31:0]        frames_done,
    output logic [31:0]        limiter_events,
    output logic [31:0]        clipped_total,
    output logic [31:0]        underflow_count,
    output logic [31:0]        overflow_count,
    output logic [15:0]        frames_left
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOG  = 3'd1;
    localparam logic [2:0] ST_EXP  = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_DVF  = 3'd5;

    localparam logic [4:0] EXP_LAST = 5'(ROOT_STEPS - 1);
    localparam logic [4:0] DIV_LAST = 5'd24;

    // control state
    logic [2:0]         state_reg,     state_next;
    logic [4:0]         cnt_reg,       cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic [14:0]        headroom_reg,  headroom_next;
    logic signed [23:0] current_reg,   current_next;
    logic signed [23:0] step_reg,      step_next;
    logic [15:0]        remaining_reg, remaining_next;
    logic [31:0]        frame_reg,     frame_next;
    logic [31:0]        limiter_reg,   limiter_next;
    logic [31:0]        clip_reg,      clip_next;
    logic [31:0]        under_reg,     under_next;
    logic [31:0]        over_reg,      over_next;

    // datapath
    logic signed [15:0] applied_reg,   applied_next;
    logic signed [5:0]  n_reg,         n_next;
    logic [23:0]        frac_reg,      frac_next;
    logic [30:0]        m_reg,         m_next;
    logic [30:0]        root_reg,      root_next;
    logic               sat_reg,       sat_next;
    logic [15:0]        rem_reg,       rem_next;
    logic [24:0]        quo_reg,       quo_next;
    logic [15:0]        div_reg,       div_next;
    logic               neg_reg,       neg_next;
    logic [19:0]        lin_out_reg,   lin_out_next;
    logic signed [15:0] appl_out_reg,  appl_out_next;
    logic [31:0]        frame_out_reg, frame_out_next;
    logic [31:0]        lim_out_reg,   lim_out_next;
    logic [31:0]        clip_out_reg,  clip_out_next;
    logic [31:0]        under_out_reg, under_out_next;
    logic [31:0]        over_out_reg,  over_out_next;
    logic [15:0]        left_out_reg,  left_out_next;

    // applied gain: floor to Q7.8, minus headroom, clamp low
    logic signed [15:0] q8_gain;
    logic signed [16:0] appl_wide;
    logic signed [15:0] applied_now;

    assign q8_gain     = current_reg[23:8];
    assign appl_wide   = {q8_gain[15], q8_gain} - $signed({2'b00, headroom_reg});
    assign applied_now = (appl_wide[16] && !appl_wide[15]) ? APPL_MIN : appl_wide[15:0];

    // frame step with 24-bit clamp
    logic signed [24:0] step_sum;
    logic signed [23:0] stepped_gain;

    assign step_sum     = {current_reg[23], current_reg} + {step_reg[23], step_reg};
    assign stepped_gain = (step_sum[24] != step_sum[23])
                          ? (step_sum[24] ? GAIN_MIN24 : GAIN_MAX24)
                          : step_sum[23:0];

    // ramp distance, split into sign and magnitude for the divider
    logic signed [24:0] ramp_diff;
    logic [24:0]        ramp_mag;

    assign ramp_diff = {target_gain[15], target_gain, 8'd0} - {current_reg[23], current_reg};
    assign ramp_mag  = ramp_diff[24] ? (25'd0 - ramp_diff) : ramp_diff;

    // divider pass: shift one dividend bit in, try to subtract
    logic [16:0] div_shift;
    logic [16:0] div_sub;
    logic        div_ge;

    assign div_shift = {rem_reg, quo_reg[24]};
    assign div_ge    = div_shift >= {1'b0, div_reg};
    assign div_sub   = div_shift - {1'b0, div_reg};

    // exponent: e = applied * K, integer part n, fraction bits below
    logic signed [38:0] exp_full;

    assign exp_full = applied_reg * LOG_K;

    // shared Q30 multiplier and root table index
    logic [61:0] mul_prod;
    logic [4:0]  root_idx;

    assign mul_prod = 62'(m_reg) * 62'(root_reg);
    assign root_idx = (cnt_reg == EXP_LAST) ? 5'd0 : cnt_reg + 5'd1;

    // final scale by 2^(n-14), round half up, clamp
    logic signed [6:0] shift_wide;
    logic [5:0]        shift_amt;
    logic [36:0]       round_sum;
    logic [36:0]       scaled;
    logic [19:0]       lin_now;

    assign shift_wide = 7'sd14 - {n_reg[5], n_reg};
    assign shift_amt  = shift_wide[5:0];
    assign round_sum  = {6'd0, m_reg} + (37'd1 << (shift_amt - 6'd1));
    assign scaled     = round_sum >> shift_amt;
    assign lin_now    = (sat_reg || (|scaled[36:20])) ? LIN_MAX : scaled[19:0];

    // sequencer and next-state logic
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        headroom_next  = headroom_reg;
        current_next   = current_reg;
        step_next      = step_reg;
        remaining_next = remaining_reg;
        frame_next     = frame_reg;
        limiter_next   = limiter_reg;
        clip_next      = clip_reg;
        under_next     = under_reg;
        over_next      = over_reg;
        applied_next   = applied_reg;
        n_next         = n_reg;
        frac_next      = frac_reg;
        m_next         = m_reg;
        root_next      = root_reg;
        sat_next       = sat_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        div_next       = div_reg;
        neg_next       = neg_reg;
        lin_out_next   = lin_out_reg;
        appl_out_next  = appl_out_reg;
        frame_out_next = frame_out_reg;
        lim_out_next   = lim_out_reg;
        clip_out_next  = clip_out_reg;
        under_out_next = under_out_reg;
        over_out_next  = over_out_reg;
        left_out_next  = left_out_reg;

        // drop a result beat once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // take a headroom write
        if (cfg_valid)
        begin
            headroom_next = headroom;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (kind)
                        KIND_FRAME:
                        begin
                            frame_next   = frame_reg + 32'd1;
                            applied_next = applied_now;
                            if (remaining_reg != 16'd0)
                            begin
                                current_next   = stepped_gain;
                                remaining_next = remaining_reg - 16'd1;
                            end
                            state_next = ST_LOG;
                        end
                        KIND_RAMP:
                        begin
                            if (ramp_frames == 16'd0)
                            begin
                                current_next   = {target_gain, 8'd0};
                                step_next      = '0;
                                remaining_next = 16'd0;
                            end
                            else
                            begin
                                remaining_next = ramp_frames;
                                div_next       = ramp_frames;
                                quo_next       = ramp_mag;
                                neg_next       = ramp_diff[24];
                                rem_next       = 16'd0;
                                cnt_next       = 5'd0;
                                state_next     = ST_DIV;
                            end
                        end
                        KIND_MUTE:
                        begin
                            current_next   = MUTE_Q16;
                            step_next      = '0;
                            remaining_next = 16'd0;
                        end
                        KIND_LIMIT: limiter_next = limiter_reg + 32'd1;
                        KIND_CLIP:  clip_next    = clip_reg + {16'd0, clipped_count};
                        KIND_UNDER: under_next   = under_reg + 32'd1;
                        KIND_OVER:  over_next    = over_reg + 32'd1;
                        KIND_READ:
                        begin
                            applied_next = applied_now;
                            state_next   = ST_LOG;
                        end
                    endcase
                end
            end

            // form the exponent, skip the multiplier above the linear range
            ST_LOG:
            begin
                n_next    = exp_full[37:32];
                frac_next = exp_full[31:8];
                m_next    = 31'd1 << 30;
                root_next = ROOT_TBL[0];
                cnt_next  = 5'd0;
                if ($signed(exp_full[37:32]) >= 6'sd5)
                begin
                    sat_next   = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    sat_next   = 1'b0;
                    state_next = ST_EXP;
                end
            end

            // apply one root factor per set fraction bit
            ST_EXP:
            begin
                if (frac_reg[23])
                begin
                    m_next = mul_prod[60:30];
                end
                frac_next = {frac_reg[22:0], 1'b0};
                root_next = ROOT_TBL[root_idx];
                cnt_next  = cnt_reg + 5'd1;
                if (cnt_reg == EXP_LAST)
                begin
                    state_next = ST_FIN;
                end
            end

            // load the result beat once the output register is free
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    lin_out_next   = lin_now;
                    appl_out_next  = applied_reg;
                    frame_out_next = frame_reg;
                    lim_out_next   = limiter_reg;
                    clip_out_next  = clip_reg;
                    under_out_next = under_reg;
                    over_out_next  = over_reg;
                    left_out_next  = remaining_reg;
                    state_next     = ST_IDLE;
                end
            end

            // restoring division, one quotient bit per cycle
            ST_DIV:
            begin
                rem_next = div_ge ? div_sub[15:0] : div_shift[15:0];
                quo_next = {quo_reg[23:0], div_ge};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_DVF;
                end
            end

            // restore the sign and clamp the step
            ST_DVF:
            begin
                if (neg_reg)
                begin
                    step_next = (quo_reg > 25'd8388608) ? GAIN_MIN24
                                                        : 24'(25'd0 - quo_reg);
                end
                else
                begin
                    step_next = (quo_reg > 25'd8388607) ? GAIN_MAX24 : quo_reg[23:0];
                end
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
            headroom_reg  <= 15'd0;
            current_reg   <= '0;
            step_reg      <= '0;
            remaining_reg <= 16'd0;
            frame_reg     <= 32'd0;
            limiter_reg   <= 32'd0;
            clip_reg      <= 32'd0;
            under_reg     <= 32'd0;
            over_reg      <= 32'd0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            headroom_reg  <= headroom_next;
            current_reg   <= current_next;
            step_reg      <= step_next;
            remaining_reg <= remaining_next;
            frame_reg     <= frame_next;
            limiter_reg   <= limiter_next;
            clip_reg      <= clip_next;
            under_reg     <= under_next;
            over_reg      <= over_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        applied_reg   <= applied_next;
        n_reg         <= n_next;
        frac_reg      <= frac_next;
        m_reg         <= m_next;
        root_reg      <= root_next;
        sat_reg       <= sat_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        div_reg       <= div_next;
        neg_reg       <= neg_next;
        lin_out_reg   <= lin_out_next;
        appl_out_reg  <= appl_out_next;
        frame_out_reg <= frame_out_next;
        lim_out_reg   <= lim_out_next;
        clip_out_reg  <= clip_out_next;
        under_out_reg <= under_out_next;
        over_out_reg  <= over_out_next;
        left_out_reg  <= left_out_next;
    end

    // ports
    assign cfg_ready       = 1'b1;
    assign in_ready        = (state_reg == ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign linear_gain     = lin_out_reg;
    assign applied_gain    = appl_out_reg;
    assign frames_done     = frame_out_reg;
    assign limiter_events  = lim_out_reg;
    assign clipped_total   = clip_out_reg;
    assign underflow_count = under_out_reg;
    assign overflow_count  = over_out_reg;
    assign frames_left     = left_out_reg;

endmodule

`default_nettype wire

### hw/rtl/fgr_chk.sv
// Port-level checker for the gain ramp fader, bound to the top level.
`default_nettype none

module fgr_chk
    import fgr_pkg::*;
(
    input wire                clk,
    input wire                rst_n,
    input wire                in_valid,
    input wire                in_ready,
    input wire  [2:0]         kind,
    input wire                out_valid,
    input wire                out_ready,
    input wire  [19:0]        linear_gain,
    input wire  signed [15:0] applied_gain
);

    // hold a stalled result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(linear_gain)
                                    && $stable(applied_gain))
        else $error("result beat changed while stalled");

    // frame and read beats occupy the exponent unit for the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == KIND_FRAME || kind == KIND_READ) |=> !in_ready)
        else $error("block ready right after a frame or read beat");

    // event counter and mute beats leave the block ready in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == KIND_LIMIT || kind == KIND_UNDER
                                 || kind == KIND_OVER || kind == KIND_MUTE) |=> in_ready)
        else $error("block stalled after a one-cycle beat");

    // a new result beat appears only as the sequencer returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result loaded while the sequencer is busy");

    // gains well above the linear range saturate
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !applied_gain[15] && (applied_gain[14:0] >= 15'd7707)
        |-> linear_gain == LIN_MAX)
        else $error("linear gain not saturated at high dB");

endmodule

bind frame_gain_ramp_with_counters fgr_chk u_fgr_chk (.*);

`default_nettype wire

### dv/frame_gain_ramp_with_counters_tb.sv
// Testbench for the frame gain ramp fader: directed and random beats checked against a predictor.
`timescale 1ns / 100ps

module frame_gain_ramp_with_counters_tb;
    import fgr_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int SETTLE_TICKS = 60;
    localparam int PHASE_BEATS  = 300;

    typedef struct {
        logic [2:0]         kind;
        logic signed [15:0] target;
        logic [15:0]        frames;
        logic [15:0]        clipped;
    } fader_beat_t;

    typedef struct {
        logic [19:0]        lin;
        logic signed [15:0] appl;
        logic [31:0]        frames;
        logic [31:0]        limiter;
        logic [31:0]        clipped;
        logic [31:0]        under;
        logic [31:0]        over;
        logic [15:0]        left;
    } gain_report_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [14:0]        cfg_headroom = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [2:0]         kind = KIND_FRAME;
    logic signed [15:0] target_gain = '0;
    logic [15:0]        ramp_frames = '0;
    logic [15:0]        clipped_count = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [19:0]        linear_gain;
    logic signed [15:0] applied_gain;
    logic [31:0]        frames_done;
    logic [31:0]        limiter_events;
    logic [31:0]        clipped_total;
    logic [31:0]        underflow_count;
    logic [31:0]        overflow_count;
    logic [15:0]        frames_left;

    // Beats waiting to go out, and reports the fader owes us
    fader_beat_t  beats_to_send[$];
    gain_report_t gain_reports_due[$];

    // Predicted fader state
    int          fader_gain_q16;
    int          fader_step_q16;
    logic [15:0] fader_frames_left;
    int          fader_headroom_q8;
    logic [31:0] tally_frames;
    logic [31:0] tally_limiter;
    logic [31:0] tally_clipped;
    logic [31:0] tally_under;
    logic [31:0] tally_over;
    logic [63:0] root_q30 [ROOT_STEPS];

    int          mismatch_count;

    frame_gain_ramp_with_counters i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .headroom        (cfg_headroom),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .target_gain     (target_gain),
        .ramp_frames     (ramp_frames),
        .clipped_count   (clipped_count),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .linear_gain     (linear_gain),
        .applied_gain    (applied_gain),
        .frames_done     (frames_done),
        .limiter_events  (limiter_events),
        .clipped_total   (clipped_total),
        .underflow_count (underflow_count),
        .overflow_count  (overflow_count),
        .frames_left     (frames_left)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Bit-by-bit floor square root
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 31; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if (c * c <= v)
                r = c;
        end
        return r;
    endfunction

    function automatic int clamp24(input longint v);
        if (v > longint'(GAIN_MAX24))
            return int'(GAIN_MAX24);
        if (v < longint'(GAIN_MIN24))
            return int'(GAIN_MIN24);
        return int'(v);
    endfunction

    // Current gain floored to Q7.8, less headroom, clamped to 16 bit
    function automatic logic signed [15:0] applied_now();
        int a;
        a = (fader_gain_q16 >>> 8) - fader_headroom_q8;
        if (a < -32768)
            a = -32768;
        if (a > 32767)
            a = 32767;
        return 16'(a);
    endfunction

    // 2^(dB * log2(10)/20) in Q4.16: integer part by shift, fraction by root factors
    function automatic logic [19:0] gain_from_db(input logic signed [15:0] a);
        longint      e;
        longint      n;
        logic [31:0] f;
        logic [63:0] m;
        logic [63:0] v;
        int          s;
        e = longint'(a) * 64'sd2786635;
        n = e >>> 32;
        f = e[31:0];
        if (n >= 5)
            return LIN_MAX;
        m = 64'd1 << 30;
        for (int k = 1; k <= ROOT_STEPS; k++)
        begin
            if (f[32 - k])
                m = (m * root_q30[k - 1]) >> 30;
        end
        s = 14 - int'(n);
        v = (m + (64'd1 << (s - 1))) >> s;
        return (v > LIN_MAX) ? LIN_MAX : v[19:0];
    endfunction

    // Advance the predicted fader by one accepted beat and queue its report
    task automatic fader_step(input fader_beat_t b);
        gain_report_t       r;
        logic signed [15:0] appl;
        longint             diff;
        bit                 reports;
        reports = 1'b0;
        appl    = '0;
        case (b.kind)
            KIND_FRAME:
            begin
                tally_frames++;
                appl = applied_now();
                if (fader_frames_left != 0)
                begin
                    fader_gain_q16 = clamp24(longint'(fader_gain_q16) + fader_step_q16);
                    fader_frames_left--;
                end
                reports = 1'b1;
            end
            KIND_RAMP:
            begin
                if (b.frames == 0)
                begin
                    fader_gain_q16    = int'(b.target) * 256;
                    fader_step_q16    = 0;
                    fader_frames_left = '0;
                end
                else
                begin
                    diff              = longint'(b.target) * 256 - fader_gain_q16;
                    fader_step_q16    = clamp24(diff / longint'(b.frames));
                    fader_frames_left = b.frames;
                end
            end
            KIND_MUTE:
            begin
                fader_gain_q16    = int'(MUTE_Q16);
                fader_step_q16    = 0;
                fader_frames_left = '0;
            end
            KIND_LIMIT: tally_limiter++;
            KIND_CLIP:  tally_clipped = tally_clipped + b.clipped;
            KIND_UNDER: tally_under++;
            KIND_OVER:  tally_over++;
            default:
            begin
                appl    = applied_now();
                reports = 1'b1;
            end
        endcase
        if (reports)
        begin
            r.lin     = gain_from_db(appl);
            r.appl    = appl;
            r.frames  = tally_frames;
            r.limiter = tally_limiter;
            r.clipped = tally_clipped;
            r.under   = tally_under;
            r.over    = tally_over;
            r.left    = fader_frames_left;
            gain_reports_due.push_back(r);
        end
    endtask

    task automatic queue_beat(input logic [2:0] k, input int tgt, input int frm, input int clp);
        fader_beat_t b;
        b.kind    = k;
        b.target  = 16'(tgt);
        b.frames  = 16'(frm);
        b.clipped = 16'(clp);
        beats_to_send.push_back(b);
    endtask

    // Mostly frames and ramps with random content, plus events, reads and mutes
    function automatic fader_beat_t random_beat();
        fader_beat_t b;
        int          pick;
        b.target  = 16'($urandom);
        b.frames  = 16'($urandom);
        b.clipped = 16'($urandom);
        pick      = $urandom_range(0, 99);
        if (pick < 40)      b.kind = KIND_FRAME;
        else if (pick < 54) b.kind = KIND_RAMP;
        else if (pick < 58) b.kind = KIND_MUTE;
        else if (pick < 62) b.kind = KIND_LIMIT;
        else if (pick < 68) b.kind = KIND_CLIP;
        else if (pick < 72) b.kind = KIND_UNDER;
        else if (pick < 76) b.kind = KIND_OVER;
        else                b.kind = KIND_READ;
        if (b.kind == KIND_RAMP)
        begin
            // keep half the targets within the useful -24 to +12 dB window
            if ($urandom_range(0, 1) == 0)
                b.target = 16'(int'($urandom_range(0, 9216)) - 6144);
            pick = $urandom_range(0, 99);
            if (pick < 15)      b.frames = '0;
            else if (pick < 80) b.frames = 16'($urandom_range(1, 24));
            else if (pick > 95) b.frames = 16'hFFFF;
        end
        return b;
    endfunction

    // Wait until nothing is queued, in flight, or owed
    task automatic wait_until_quiet();
        @(negedge clk);
        while (beats_to_send.size() != 0 || in_valid || gain_reports_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_headroom(input logic [14:0] v);
        wait_until_quiet();
        repeat (SETTLE_TICKS) @(posedge clk);
        cfg_valid    <= 1'b1;
        cfg_headroom <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid         <= 1'b0;
        fader_headroom_q8 = int'(v);
        @(negedge clk);
    endtask

    // Driver: send queued beats in bursts with random gaps
    int          burst_left = 1;
    int          gap_left   = 0;
    fader_beat_t held_beat;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                fader_step(held_beat);
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0 || beats_to_send.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    held_beat     = beats_to_send.pop_front();
                    in_valid      <= 1'b1;
                    kind          <= held_beat.kind;
                    target_gain   <= held_beat.target;
                    ramp_frames   <= held_beat.frames;
                    clipped_count <= held_beat.clipped;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // Monitor: stall the result side on its own pattern and check each beat
    int           ready_mode = 0;
    int           ready_span = 0;
    gain_report_t due;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (gain_reports_due.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result beat with nothing expected, expected none actual %0d",
                             $time, applied_gain);
                end
                else
                begin
                    due = gain_reports_due.pop_front();
                    check_field("linear_gain", due.lin, linear_gain);
                    check_field("applied_gain", due.appl, applied_gain);
                    check_field("frames_done", due.frames, frames_done);
                    check_field("limiter_events", due.limiter, limiter_events);
                    check_field("clipped_total", due.clipped, clipped_total);
                    check_field("underflow_count", due.under, underflow_count);
                    check_field("overflow_count", due.over, overflow_count);
                    check_field("frames_left", due.left, frames_left);
                end
            end
            // pick a new stall mode now and then: open, coin flip, mostly stalled
            if (ready_span == 0)
            begin
                ready_mode = $urandom_range(0, 2);
                ready_span = $urandom_range(32, 256);
            end
            ready_span--;
            case (ready_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 1) == 0);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Watchdog: end the run if no beat moves for too long
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [63:0]  root;
        logic [14:0]  headroom_plan [6];

        // fraction factors 2^(2^-k) in Q30
        root = 64'd2 << 30;
        for (int k = 0; k < ROOT_STEPS; k++)
        begin
            root        = floor_sqrt(root << 30);
            root_q30[k] = root;
        end
        fader_gain_q16    = 0;
        fader_step_q16    = 0;
        fader_frames_left = '0;
        fader_headroom_q8 = 0;
        tally_frames      = '0;
        tally_limiter     = '0;
        tally_clipped     = '0;
        tally_under       = '0;
        tally_over        = '0;
        mismatch_count    = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extremes, jump and ramp, step clamp, long ramp, mute, events
        queue_beat(KIND_READ, 0, 0, 0);
        queue_beat(KIND_FRAME, 0, 0, 0);
        queue_beat(KIND_RAMP, 32767, 0, 0);
        queue_beat(KIND_FRAME, 0, 0, 0);
        queue_beat(KIND_RAMP, -32768, 3, 0);
        repeat (4) queue_beat(KIND_FRAME, 0, 0, 0);
        queue_beat(KIND_RAMP, -32768, 0, 0);
        queue_beat(KIND_FRAME, 0, 0, 0);
        queue_beat(KIND_RAMP, 32767, 1, 0);
        repeat (2) queue_beat(KIND_FRAME, 0, 0, 0);
        queue_beat(KIND_RAMP, 0, 65535, 0);
        repeat (2) queue_beat(KIND_FRAME, 0, 0, 0);
        queue_beat(KIND_MUTE, 0, 0, 0);
        queue_beat(KIND_FRAME, 0, 0, 0);
        queue_beat(KIND_LIMIT, 0, 0, 0);
        queue_beat(KIND_CLIP, 0, 0, 65535);
        queue_beat(KIND_UNDER, 0, 0, 0);
        queue_beat(KIND_OVER, 0, 0, 0);
        queue_beat(KIND_READ, 0, 0, 0);
        wait_until_quiet();

        // Random phases, each under its own headroom
        headroom_plan[0] = 15'h7FFF;
        headroom_plan[1] = 15'd0;
        headroom_plan[2] = 15'd384;
        headroom_plan[3] = 15'($urandom);
        headroom_plan[4] = 15'd7680;
        headroom_plan[5] = 15'($urandom);
        foreach (headroom_plan[p])
        begin
            set_headroom(headroom_plan[p]);
            repeat (PHASE_BEATS) beats_to_send.push_back(random_beat());
        end

        wait_until_quiet();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
